>>> hw/rtl/rmsle_pkg.sv
// ----------------------------------------------------------------------------
// rmsle_pkg
// Shared constants and helpers for the RMSLE core.
// ----------------------------------------------------------------------------
`default_nettype none

package rmsle_pkg;

   // default number of fraction bits in the logarithm
   localparam int LOG_FRAC_BITS_DEF = 16;

   // round(ln2 * 2^32)
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;

   // 1.0 in Q16.16
   localparam logic [63:0] ONE_Q16 = 64'd65536;

   // width of the Q16.16 squared log difference
   localparam int SQ_W = 26;

   // leading-one position of y, where h = y[32:16] is never zero
   function automatic logic [5:0] lead_one(input logic [16:0] h);
      logic [5:0] pos;
      pos = 6'd16;
      for (int i = 0; i < 17; i++) begin
         if (h[i]) begin
            pos = 6'(16 + i);
         end
      end
      return pos;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rmsle_req_if.sv
// ----------------------------------------------------------------------------
// rmsle_req_if
// Input channel: one beat carries a value pair, a weight and the last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmsle_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] actual_value;
   logic [31:0] predicted_value;
   logic [31:0] sample_weight;
   logic        last_item;

   modport source (output valid, actual_value, predicted_value, sample_weight, last_item,
                   input ready);
   modport sink   (input valid, actual_value, predicted_value, sample_weight, last_item,
                   output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rmsle_rsp_if.sv
// ----------------------------------------------------------------------------
// rmsle_rsp_if
// Result channel: one beat carries the RMSLE value and the zero-weight flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmsle_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] error_value;
   logic        zero_weight_error;

   modport source (output valid, error_value, zero_weight_error, input ready);
   modport sink   (input valid, error_value, zero_weight_error, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rmsle_mul.sv
// ----------------------------------------------------------------------------
// rmsle_mul
// Shared 32x32 multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module rmsle_mul (
   input  wire logic        clock,
   input  wire logic        enable,
   input  wire logic [31:0] op_a,
   input  wire logic [31:0] op_b,
   output logic      [63:0] product
);

   logic [63:0] prod_ff;
   logic [63:0] prod_in;

   assign prod_in = 64'(op_a) * 64'(op_b);
   assign product = prod_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/rmsle_root.sv
// ----------------------------------------------------------------------------
// rmsle_root
// Iterative sqrt(num * 2^32 / den): 96 restoring divide steps, then 32
// square-root steps, both on one shared 64-bit subtractor.
// ----------------------------------------------------------------------------
`default_nettype none

module rmsle_root (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] num,
   input  wire logic [63:0] den,
   output logic             done,
   output logic      [31:0] root
);

   localparam logic [1:0] R_IDLE = 2'd0;
   localparam logic [1:0] R_DIV  = 2'd1;
   localparam logic [1:0] R_SQRT = 2'd2;
   localparam logic [1:0] R_DONE = 2'd3;

   localparam logic [6:0] DIV_LAST  = 7'd95;
   localparam logic [6:0] SQRT_LAST = 7'd31;

   logic [1:0]  state_ff, state_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [63:0] num_ff, num_in;
   logic [63:0] den_ff, den_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] q_ff, q_in;
   logic        over_ff, over_in;
   logic [63:0] n_ff, n_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_ff, bit_in;

   logic [63:0] rem_sh;
   logic [63:0] sub_a, sub_b;
   logic [64:0] diff;
   logic        take;

   assign rem_sh = {rem_ff[62:0], num_ff[63]};

   // shared subtractor
   always_comb begin
      if (state_ff == R_SQRT) begin
         sub_a = n_ff;
         sub_b = res_ff + bit_ff;
      end else begin
         sub_a = rem_sh;
         sub_b = den_ff;
      end
   end

   assign diff = {1'b0, sub_a} - {1'b0, sub_b};
   assign take = rem_ff[63] | ~diff[64];

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      over_in  = over_ff;
      n_in     = n_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      case (state_ff)
         R_IDLE: begin
            if (start) begin
               num_in   = num;
               den_in   = den;
               rem_in   = '0;
               q_in     = '0;
               over_in  = 1'b0;
               cnt_in   = '0;
               state_in = R_DIV;
            end
         end
         R_DIV: begin
            rem_in  = take ? diff[63:0] : rem_sh;
            q_in    = {q_ff[62:0], take};
            over_in = over_ff | q_ff[63];
            num_in  = {num_ff[62:0], 1'b0};
            cnt_in  = cnt_ff + 7'd1;
            if (cnt_ff == DIV_LAST) begin
               // saturate the quotient, then seed the root
               n_in     = (over_ff | q_ff[63]) ? '1 : {q_ff[62:0], take};
               res_in   = '0;
               bit_in   = 64'h4000_0000_0000_0000;
               cnt_in   = '0;
               state_in = R_SQRT;
            end
         end
         R_SQRT: begin
            if (!diff[64]) begin
               n_in   = diff[63:0];
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == SQRT_LAST) begin
               state_in = R_DONE;
            end
         end
         R_DONE: begin
            state_in = R_IDLE;
         end
         default: begin
            state_in = R_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= R_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff  <= cnt_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      over_ff <= over_in;
      n_ff    <= n_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
   end

   assign done = (state_ff == R_DONE);
   assign root = res_ff[31:0];

endmodule

`default_nettype wire

>>> hw/rtl/root_mean_squared_log_error_core.sv
// ----------------------------------------------------------------------------
// root_mean_squared_log_error_core
// Streaming RMSLE over Q16.16 value pairs with optional weights.
// ----------------------------------------------------------------------------
// One item is taken at a time; req ready is high only while the sequencer is
// idle. Each item runs two logarithms (LOG_FRAC_BITS squarings each), the
// square of their difference and, in weighted mode, the weight product, all
// on one shared 32x32 multiplier with a registered product. The item flagged
// last then runs the 96-step divide and 32-step square root, and the result
// beat is offered on rsp; a new item can be accepted while that beat waits.
// A zero weight sum returns 0 with zero_weight_error set.
// Register 0 (byte 0x0) bit 0 selects weighted mode.
// ----------------------------------------------------------------------------
`default_nettype none

module root_mean_squared_log_error_core
   import rmsle_pkg::*;
#(
   parameter int LOG_FRAC_BITS = LOG_FRAC_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   rmsle_req_if.sink        req_chan,
   rmsle_rsp_if.source      rsp_chan,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   localparam int L2_W     = LOG_FRAC_BITS + 5;
   localparam int CNT_W    = $clog2(LOG_FRAC_BITS);
   localparam int SQ_SHIFT = 2 * LOG_FRAC_BITS - 16;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_NORM     = 4'd1;
   localparam logic [3:0] S_SQR      = 4'd2;
   localparam logic [3:0] S_SQR_WB   = 4'd3;
   localparam logic [3:0] S_LN       = 4'd4;
   localparam logic [3:0] S_LN_WB    = 4'd5;
   localparam logic [3:0] S_DIFF     = 4'd6;
   localparam logic [3:0] S_DIFF_WB  = 4'd7;
   localparam logic [3:0] S_WMUL     = 4'd8;
   localparam logic [3:0] S_WMUL_WB  = 4'd9;
   localparam logic [3:0] S_ACC      = 4'd10;
   localparam logic [3:0] S_FIN      = 4'd11;
   localparam logic [3:0] S_FIN_WAIT = 4'd12;

   localparam logic [CNT_W-1:0] SQR_LAST = CNT_W'(LOG_FRAC_BITS - 1);

   logic [3:0]               state_ff, state_in;
   logic                     mode_ff, mode_in;
   logic [31:0]              act_ff, act_in;
   logic [31:0]              pred_ff, pred_in;
   logic [31:0]              w_ff, w_in;
   logic                     last_ff, last_in;
   logic                     sel_ff, sel_in;
   logic [31:0]              m_ff, m_in;
   logic [5:0]               p_ff, p_in;
   logic [LOG_FRAC_BITS-1:0] frac_ff, frac_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [L2_W-1:0]          la_ff, la_in;
   logic [L2_W-1:0]          lp_ff, lp_in;
   logic [SQ_W-1:0]          sq_ff, sq_in;
   logic [63:0]              term_ff, term_in;
   logic [63:0]              ssum_ff, ssum_in;
   logic [63:0]              wsum_ff, wsum_in;
   logic                     rvalid_ff, rvalid_in;
   logic [31:0]              rvalue_ff, rvalue_in;
   logic                     rzwe_ff, rzwe_in;

   logic        mul_en;
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;
   logic        root_start;
   logic        root_done;
   logic [31:0] root_val;

   logic [32:0]     y;
   logic [5:0]      p_new;
   logic [4:0]      nsh;
   logic [32:0]     sqr_top;
   logic [L2_W-1:0] l2;
   logic [63:0]     ln_sum;
   logic [L2_W-1:0] dabs;
   logic [64:0]     ssum_add, wsum_add;
   logic [63:0]     wadd;
   logic            csr_wr;
   logic            req_fire;
   logic            rsp_free;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {31'b0, mode_ff} : 32'b0;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid & (state_ff == S_IDLE);
   assign rsp_free       = ~rvalid_ff | rsp_chan.ready;

   // normalize v+1 so its leading one sits at bit 31
   assign y     = {1'b0, (sel_ff ? pred_ff : act_ff)} + 33'd65536;
   assign p_new = lead_one(y[32:16]);
   assign nsh   = 5'(6'd31 - p_new);

   assign sqr_top = prod[63:31];
   assign l2      = {5'(p_ff - 6'd16), frac_ff};
   assign ln_sum  = prod + 64'h0000_0000_8000_0000;
   assign dabs    = (la_ff >= lp_ff) ? (la_ff - lp_ff) : (lp_ff - la_ff);

   // saturating accumulator adds
   assign wadd     = mode_ff ? 64'(w_ff) : ONE_Q16;
   assign ssum_add = {1'b0, ssum_ff} + {1'b0, term_ff};
   assign wsum_add = {1'b0, wsum_ff} + {1'b0, wadd};

   // shared multiplier operands
   always_comb begin
      mul_en = 1'b1;
      mul_a  = '0;
      mul_b  = '0;
      case (state_ff)
         S_SQR: begin
            mul_a = m_ff;
            mul_b = m_ff;
         end
         S_LN: begin
            mul_a = 32'(l2);
            mul_b = LN2_Q32;
         end
         S_DIFF: begin
            mul_a = 32'(dabs);
            mul_b = 32'(dabs);
         end
         S_WMUL: begin
            mul_a = 32'(sq_ff);
            mul_b = w_ff;
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   rmsle_mul u_mul (
      .clock   (clock),
      .enable  (mul_en),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (prod)
   );

   rmsle_root u_root (
      .clock (clock),
      .reset (reset),
      .start (root_start),
      .num   (ssum_ff),
      .den   (wsum_ff),
      .done  (root_done),
      .root  (root_val)
   );

   // sequencer
   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      act_in     = act_ff;
      pred_in    = pred_ff;
      w_in       = w_ff;
      last_in    = last_ff;
      sel_in     = sel_ff;
      m_in       = m_ff;
      p_in       = p_ff;
      frac_in    = frac_ff;
      cnt_in     = cnt_ff;
      la_in      = la_ff;
      lp_in      = lp_ff;
      sq_in      = sq_ff;
      term_in    = term_ff;
      ssum_in    = ssum_ff;
      wsum_in    = wsum_ff;
      rvalid_in  = rvalid_ff & ~rsp_chan.ready;
      rvalue_in  = rvalue_ff;
      rzwe_in    = rzwe_ff;
      root_start = 1'b0;

      if (csr_wr && csr_paddr[2] == 1'b0) begin
         mode_in = csr_pwdata[0];
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               act_in   = req_chan.actual_value;
               pred_in  = req_chan.predicted_value;
               w_in     = req_chan.sample_weight;
               last_in  = req_chan.last_item;
               sel_in   = 1'b0;
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            m_in     = y[32] ? y[32:1] : (y[31:0] << nsh);
            p_in     = p_new;
            frac_in  = '0;
            cnt_in   = '0;
            state_in = S_SQR;
         end
         S_SQR: begin
            state_in = S_SQR_WB;
         end
         S_SQR_WB: begin
            // one fraction bit per squaring
            m_in    = sqr_top[32] ? sqr_top[32:1] : sqr_top[31:0];
            frac_in = {frac_ff[LOG_FRAC_BITS-2:0], sqr_top[32]};
            cnt_in  = cnt_ff + CNT_W'(1);
            state_in = (cnt_ff == SQR_LAST) ? S_LN : S_SQR;
         end
         S_LN: begin
            state_in = S_LN_WB;
         end
         S_LN_WB: begin
            if (sel_ff) begin
               lp_in    = ln_sum[32 +: L2_W];
               state_in = S_DIFF;
            end else begin
               la_in    = ln_sum[32 +: L2_W];
               sel_in   = 1'b1;
               state_in = S_NORM;
            end
         end
         S_DIFF: begin
            state_in = S_DIFF_WB;
         end
         S_DIFF_WB: begin
            sq_in = prod[SQ_SHIFT +: SQ_W];
            if (mode_ff) begin
               state_in = S_WMUL;
            end else begin
               term_in  = 64'(prod[SQ_SHIFT +: SQ_W]);
               state_in = S_ACC;
            end
         end
         S_WMUL: begin
            state_in = S_WMUL_WB;
         end
         S_WMUL_WB: begin
            term_in  = {16'b0, prod[63:16]};
            state_in = S_ACC;
         end
         S_ACC: begin
            ssum_in  = ssum_add[64] ? '1 : ssum_add[63:0];
            wsum_in  = wsum_add[64] ? '1 : wsum_add[63:0];
            state_in = last_ff ? S_FIN : S_IDLE;
         end
         S_FIN: begin
            if (rsp_free) begin
               if (wsum_ff == 64'd0) begin
                  rvalid_in = 1'b1;
                  rvalue_in = '0;
                  rzwe_in   = 1'b1;
                  ssum_in   = '0;
                  wsum_in   = '0;
                  state_in  = S_IDLE;
               end else begin
                  root_start = 1'b1;
                  state_in   = S_FIN_WAIT;
               end
            end
         end
         S_FIN_WAIT: begin
            if (root_done) begin
               rvalid_in = 1'b1;
               rvalue_in = root_val;
               rzwe_in   = 1'b0;
               ssum_in   = '0;
               wsum_in   = '0;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         mode_ff   <= 1'b0;
         ssum_ff   <= '0;
         wsum_ff   <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         mode_ff   <= mode_in;
         ssum_ff   <= ssum_in;
         wsum_ff   <= wsum_in;
         rvalid_ff <= rvalid_in;
      end
      act_ff    <= act_in;
      pred_ff   <= pred_in;
      w_ff      <= w_in;
      last_ff   <= last_in;
      sel_ff    <= sel_in;
      m_ff      <= m_in;
      p_ff      <= p_in;
      frac_ff   <= frac_in;
      cnt_ff    <= cnt_in;
      la_ff     <= la_in;
      lp_ff     <= lp_in;
      sq_ff     <= sq_in;
      term_ff   <= term_in;
      rvalue_ff <= rvalue_in;
      rzwe_ff   <= rzwe_in;
   end

   // result beat
   assign rsp_chan.valid             = rvalid_ff;
   assign rsp_chan.error_value       = rvalue_ff;
   assign rsp_chan.zero_weight_error = rzwe_ff;

endmodule

`default_nettype wire

>>> tb/rmsle_checker.sv
// ----------------------------------------------------------------------------
// rmsle_checker
// Watches the request and result channels of the RMSLE core, keeps its own
// running sums per vector and compares every result beat against the
// oldest predicted value.
// ----------------------------------------------------------------------------
`default_nettype none

module rmsle_checker
   import rmsle_pkg::*;
#(
   parameter int LOG_FRAC_BITS = LOG_FRAC_BITS_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   weighted_mode,
   rmsle_req_if        req_chan,
   rmsle_rsp_if        rsp_chan,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] error_value;
      logic        zero_weight_error;
   } rmsle_result_type;

   rmsle_result_type expected_results[$];
   logic [63:0]      sq_total;
   logic [63:0]      wt_total;

   // ln(v+1) in Q.LOG_FRAC_BITS, by repeated squaring of the mantissa
   function automatic logic [63:0] log1p_fixed(input logic [31:0] v);
      logic [63:0]  y;
      logic [63:0]  m;
      logic [63:0]  frac;
      logic [63:0]  l2;
      logic [127:0] prod;
      int           p;
      y = {32'd0, v} + ONE_Q16;
      p = 32;
      frac = 0;
      while (p > 16 && y[p] == 1'b0) p--;
      m = (p > 31) ? (y >> (p - 31)) : (y << (31 - p));
      for (int i = 0; i < LOG_FRAC_BITS; i++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= 64'h1_0000_0000) begin
            frac[0] = 1'b1;
            m = m >> 1;
         end
      end
      l2 = (64'(p - 16) << LOG_FRAC_BITS) | frac;
      prod = 128'(l2) * 128'(LN2_Q32) + (128'd1 << 31);
      return prod[95:32];
   endfunction

   function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
   endfunction

   // floor(num * 2^32 / den), saturated to 64 bits
   function automatic logic [63:0] ratio_q32(input logic [63:0] num, input logic [63:0] den);
      logic [95:0] q;
      q = {num, 32'd0} / {32'd0, den};
      return (q[95:64] != 0) ? '1 : q[63:0];
   endfunction

   function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   assign pending_count = expected_results.size();

   // predict on each accepted request beat, check each result beat
   always @(posedge clock) begin
      logic [63:0]      la, lp, d, sq, term, wadd;
      logic [127:0]     wprod;
      rmsle_result_type exp_r;
      if (reset) begin
         sq_total <= 0;
         wt_total <= 0;
         fail_count <= 0;
         expected_results.delete();
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            la = log1p_fixed(req_chan.actual_value);
            lp = log1p_fixed(req_chan.predicted_value);
            d = (la >= lp) ? la - lp : lp - la;
            sq = (d * d) >> (2 * LOG_FRAC_BITS - 16);
            if (weighted_mode) begin
               wprod = 128'(sq) * 128'(req_chan.sample_weight);
               term = wprod[79:16];
               wadd = {32'd0, req_chan.sample_weight};
            end else begin
               term = sq;
               wadd = ONE_Q16;
            end
            term = add_sat(sq_total, term);
            wadd = add_sat(wt_total, wadd);
            if (req_chan.last_item) begin
               if (wadd == 0) begin
                  exp_r = '{error_value: 32'd0, zero_weight_error: 1'b1};
               end else begin
                  exp_r.error_value = 32'(floor_sqrt(ratio_q32(term, wadd)));
                  exp_r.zero_weight_error = 1'b0;
               end
               expected_results.push_back(exp_r);
               sq_total <= 0;
               wt_total <= 0;
            end else begin
               sq_total <= term;
               wt_total <= wadd;
            end
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_results.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result beat: value %h zwe %b",
                           rsp_chan.error_value, rsp_chan.zero_weight_error);
               fail_count <= fail_count + 1;
            end else begin
               exp_r = expected_results.pop_front();
               if (exp_r.error_value !== rsp_chan.error_value ||
                   exp_r.zero_weight_error !== rsp_chan.zero_weight_error) begin
                  if (fail_count < 10)
                     $display("result mismatch: exp %h/%b got %h/%b",
                              exp_r.error_value, exp_r.zero_weight_error,
                              rsp_chan.error_value, rsp_chan.zero_weight_error);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives vectors of value pairs into the RMSLE core in simple and weighted
// mode with varying idle and stall pressure; the checker grades the results.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import rmsle_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] REG_WEIGHTED_MODE = 3'h0;

   logic        clock;
   logic        reset;
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   logic        weighted_mode;
   int          fail_count;
   int          pending_count;
   int          send_idle_pct;
   int          recv_stall_pct;

   rmsle_req_if req_chan();
   rmsle_rsp_if rsp_chan();

   root_mean_squared_log_error_core uut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   rmsle_checker chk (
      .clock(clock), .reset(reset), .weighted_mode(weighted_mode),
      .req_chan(req_chan), .rsp_chan(rsp_chan),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // time limit
   initial begin
      #40ms;
      $display("tb_top: done, errors");
      $finish;
   end

   // result side stalls
   always @(posedge clock) begin
      if (reset) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic write_mode(input logic value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= REG_WEIGHTED_MODE;
      csr_pwdata <= {31'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      weighted_mode <= value;
   endtask

   // one request beat, with optional idle cycles before it; valid stays up
   // after the accept until the next beat or an idle cycle replaces it
   task automatic send_beat(input logic [31:0] a, input logic [31:0] p,
                            input logic [31:0] w, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.actual_value <= a;
      req_chan.predicted_value <= p;
      req_chan.sample_weight <= w;
      req_chan.last_item <= last;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(4))
         0: return $urandom;
         1: return $urandom_range(32'h3_0000);
         2: return 32'hFFFF_FFFF - $urandom_range(15);
         3: return 32'd1 << $urandom_range(31);
         default: return $urandom_range(255);
      endcase
   endfunction

   function automatic logic [31:0] rand_weight();
      case ($urandom_range(5))
         0: return 32'd0;
         1: return $urandom;
         2: return 32'hFFFF_FFFF;
         default: return $urandom_range(32'h4_0000);
      endcase
   endfunction

   // drop valid, wait for all results, then idle through a possible trailing item
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   initial begin
      int len;
      reset = 1'b1;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      weighted_mode = 1'b0;
      req_chan.valid = 1'b0;
      req_chan.actual_value = '0; req_chan.predicted_value = '0;
      req_chan.sample_weight = '0; req_chan.last_item = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes in simple mode
      send_beat(32'd0, 32'd0, 32'd0, 1'b1);
      send_beat(32'hFFFF_FFFF, 32'd0, 32'd0, 1'b1);
      send_beat(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_beat(32'h0001_0000, 32'h0000_FFFF, 32'd5, 1'b1);
      send_beat(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 1'b1);
      drain();

      // directed: weighted mode, zero weight sum, large weights
      write_mode(1'b1);
      send_beat(32'hFFFF_FFFF, 32'd0, 32'd0, 1'b1);
      send_beat(32'd7, 32'd9, 32'd0, 1'b0);
      send_beat(32'd7, 32'd9, 32'd0, 1'b1);
      for (int i = 0; i < 6; i++)
         send_beat(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, i == 5);
      send_beat(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b0);
      send_beat(32'd0, 32'd0, 32'd1, 1'b1);
      send_beat(32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 1'b1);
      drain();

      // random vectors across idle phases and both modes
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
            default: begin send_idle_pct = 15; recv_stall_pct = 15; end
         endcase
         write_mode(ph[0] ^ ph[2]);
         for (int n = 0; n < 110; n += len) begin
            len = $urandom_range(6, 1);
            for (int k = 0; k < len; k++)
               send_beat(rand_value(), rand_value(), rand_weight(), k == len - 1);
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
